### rtl/lr_pkg.sv
`timescale 1ns / 1ps
package lr_pkg;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd800;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd800;

  typedef struct packed {
    logic line_active;
    logic fire;
    logic fire_last;
  } lr_status_t;

endpackage

### rtl/lr_if.sv
`timescale 1ns / 1ps
interface lr_cmd_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_pix_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         on_screen;
  logic                         last;

  modport source (output valid, pixel_x, pixel_y, on_screen, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, on_screen, last, output ready);
endinterface

### rtl/line_rasterizer_unit.sv
`timescale 1ns / 1ps
// channel   dir  handshake        payload
// cmd       in   valid / ready    action, start_x, start_y, end_x, end_y
// pix       out  valid / ready    pixel_x, pixel_y, on_screen, last
// cfg       in   cfg_we           cfg_index, cfg_wdata (no read-back)
//
// One word per cycle sustained on cmd and pix while pix does not stall; a step word passes
// through one queue slot, then the output register, before it is shown on pix.
// The front end sets up each line combinationally and writes a two-entry queue.
// Synchronous reset clears the queue, the line state and the output register.
// A stall on pix holds the back end; the queue then fills and drops cmd ready.
module line_rasterizer_unit import lr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  lr_cmd_if.sink               cmd,
  lr_pix_if.source             pix
);

  localparam int CMD_W = 4 * COORD_BITS + 5;

  logic [CFG_W-1:0] screen_width, screen_height;
  logic             q_push, q_ready, q_pop, q_valid;
  logic [CMD_W-1:0] q_wdata, q_rdata;
  lr_status_t       status;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lr_front #(.COORD_BITS(COORD_BITS), .CMD_W(CMD_W)) u_front (
    .cmd     (cmd),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_ready (q_ready)
  );

  lr_queue #(.WIDTH(CMD_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .ready (q_ready),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  lr_back #(.COORD_BITS(COORD_BITS), .CMD_W(CMD_W)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pix           (pix),
    .status        (status)
  );

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    status.fire_last |=> !status.line_active)
    else $error("line still active after its last pixel");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (rst)
    status.fire |=> pix.valid)
    else $error("pixel produced but output register empty");

  a_fire_needs_line: assert property (@(posedge clk) disable iff (rst)
    status.fire |-> q_valid && status.line_active)
    else $error("pixel produced without a queued step on an active line");

endmodule

### rtl/lr_front.sv
`timescale 1ns / 1ps
module lr_front import lr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int CMD_W      = 4 * COORD_BITS + 5
) (
  lr_cmd_if.sink           cmd,
  output logic             q_push,
  output logic [CMD_W-1:0] q_wdata,
  input  logic             q_ready
);

  localparam int C = COORD_BITS;

  logic signed [C:0]   dx, dy;
  logic        [C:0]   adx, ady;
  logic                major_is_y;
  logic                step_down;
  logic signed [C-1:0] a1, b1, a2, b2;
  logic        [C:0]   da, db;
  logic                swap;
  logic signed [C-1:0] cur_major, cur_minor;
  logic                is_start;

  always_comb begin
    dx = {cmd.end_x[C-1], cmd.end_x} - {cmd.start_x[C-1], cmd.start_x};
    dy = {cmd.end_y[C-1], cmd.end_y} - {cmd.start_y[C-1], cmd.start_y};
    adx = dx[C] ? $unsigned(-dx) : $unsigned(dx);
    ady = dy[C] ? $unsigned(-dy) : $unsigned(dy);
    major_is_y = adx < ady;
    step_down = ((dx > 0) && (dy < 0)) || ((dx < 0) && (dy > 0));
    if (major_is_y) begin
      a1 = cmd.start_y; b1 = cmd.start_x; a2 = cmd.end_y; b2 = cmd.end_x;
      da = ady; db = adx;
    end else begin
      a1 = cmd.start_x; b1 = cmd.start_y; a2 = cmd.end_x; b2 = cmd.end_y;
      da = adx; db = ady;
    end
    swap = (b2 < b1) || ((b2 == b1) && (a2 < a1));
    cur_major = swap ? a2 : a1;
    cur_minor = swap ? b2 : b1;
  end

  always_comb begin
    unique case (action_t'(cmd.action))
      ACT_START: is_start = 1'b1;
      ACT_STEP:  is_start = 1'b0;
    endcase
  end

  assign q_wdata   = {is_start, major_is_y, step_down, cur_major, cur_minor, da, db};
  assign q_push    = cmd.valid;
  assign cmd.ready = q_ready;

endmodule

### rtl/lr_queue.sv
`timescale 1ns / 1ps
module lr_queue import lr_pkg::*; #(
  parameter int WIDTH = 53
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             ready,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] slots [DEPTH];
  logic             wptr, rptr;
  logic [1:0]       count;
  logic             do_push, do_pop;

  assign ready   = (count != 2'(DEPTH));
  assign valid   = (count != 2'd0);
  assign rdata   = slots[rptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/lr_back.sv
`timescale 1ns / 1ps
module lr_back import lr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int CMD_W      = 4 * COORD_BITS + 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [CMD_W-1:0] q_rdata,
  output logic             q_pop,
  input  logic [CFG_W-1:0] screen_width,
  input  logic [CFG_W-1:0] screen_height,
  lr_pix_if.source         pix,
  output lr_status_t       status
);

  localparam int C  = COORD_BITS;
  localparam int CW = (C > CFG_W) ? C : CFG_W;

  logic                c_start, c_is_y, c_down;
  logic signed [C-1:0] c_major, c_minor;
  logic        [C:0]   c_da, c_db;

  logic signed [C-1:0] cur_major, cur_minor;
  logic signed [C+1:0] err_term;
  logic        [C:0]   major_delta, minor_delta, pixels_left;
  logic                major_is_y, major_step_down;
  logic                out_valid;

  logic                out_free, active, fire;
  logic signed [C-1:0] px, py;
  logic        [CW-1:0] px_u, py_u;
  logic                on_now, last_now;
  logic signed [C+1:0] err_sub, err_next;

  assign {c_start, c_is_y, c_down, c_major, c_minor, c_da, c_db} = q_rdata;

  always_comb begin
    out_free = !out_valid || pix.ready;
    active   = (pixels_left != '0);
    q_pop    = q_valid && (c_start || !active || out_free);
    fire     = q_pop && !c_start && active;
    px       = major_is_y ? cur_minor : cur_major;
    py       = major_is_y ? cur_major : cur_minor;
    px_u     = CW'($unsigned(px));
    py_u     = CW'($unsigned(py));
    on_now   = !px[C-1] && !py[C-1] && (px_u < CW'(screen_width))
               && (py_u < CW'(screen_height));
    last_now = (pixels_left == (C+1)'(1));
    err_sub  = err_term[C+1] ? err_term : err_term - (C+2)'(major_delta);
    err_next = err_sub + (C+2)'(minor_delta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_major       <= '0;
      cur_minor       <= '0;
      err_term        <= '0;
      major_delta     <= '0;
      minor_delta     <= '0;
      pixels_left     <= '0;
      major_is_y      <= 1'b0;
      major_step_down <= 1'b0;
    end else if (q_pop && c_start) begin
      cur_major       <= c_major;
      cur_minor       <= c_minor;
      err_term        <= (C+2)'(c_db) - (C+2)'(c_da);
      major_delta     <= c_da;
      minor_delta     <= c_db;
      pixels_left     <= c_da;
      major_is_y      <= c_is_y;
      major_step_down <= c_down;
    end else if (fire) begin
      if (!err_term[C+1]) begin
        cur_minor <= cur_minor + C'(1);
      end
      err_term    <= err_next;
      cur_major   <= major_step_down ? cur_major - C'(1) : cur_major + C'(1);
      pixels_left <= pixels_left - (C+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pix.pixel_x   <= px;
      pix.pixel_y   <= py;
      pix.on_screen <= on_now;
      pix.last      <= last_now;
    end
  end

  assign pix.valid          = out_valid;
  assign status.line_active = active;
  assign status.fire        = fire;
  assign status.fire_last   = fire && last_now;

endmodule
